>>> src/assert_macros.svh
// Assertion macros used by the RTL of the color converter.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)
`endif
`endif

>>> src/hsvd_pkg.sv
// Package for the HSV to RGB PWM duty converter: field widths,
// limits, reciprocal constants and the hue sector codes. No dependencies.
`default_nettype none
package hsvd_pkg;

  localparam int HueW   = 9;
  localparam int PctW   = 7;
  localparam int LevelW = 8;
  localparam int DutyW  = 10;
  localparam int InW    = 24;
  localparam int OutW   = 56;

  localparam logic [HueW-1:0] HueLimit = 9'd360;
  localparam logic [HueW-1:0] HueMax   = 9'd359;
  localparam logic [PctW-1:0] PctMax   = 7'd100;
  localparam logic [5:0]      SectorSpan = 6'd60;

  // floor(x/60) = (x*Recip60) >> 20 for x < 8192
  localparam logic [14:0] Recip60  = 15'd17477;
  // floor(x/100) = (x*Recip100) >> 20 for x <= 10000
  localparam logic [13:0] Recip100 = 14'd10486;
  // floor(x*255/100) = (x*LevelScale) >> 16 for x <= 100
  localparam logic [17:0] LevelScale = 18'd167117;
  // floor(x*1000/255) = (x*DutyScale) >> 16 for x <= 255
  localparam logic [17:0] DutyScale  = 18'd257004;

  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

endpackage
`default_nettype wire

>>> src/hsv_to_rgb_pwm_duty.sv
// HSV to RGB color converter with PWM duty scaling, seven-stage pipeline.
// Depends on hsvd_pkg and assert_macros.svh.
//
// Usage:
//   Slave channel s_*: one color per transaction, hue (degrees), saturation
//   and brightness (percent). Hue 360 and above reads as 359, saturation and
//   brightness above 100 read as 100.
//   Master channel m_*: one result per color: 8-bit red, green, blue levels
//   and their 0..1000 PWM duties, in input order.
//   Throughput: one color per cycle while m_tready stays high.
//   Seven register stages, each with its own valid bit: sector split,
//   saturation products, divide by 60, brightness products, divide by 100,
//   level scaling with sector select, duty scaling.
//   Stall: each stage holds while the stage after it is full and blocked,
//   so empty stages keep filling and s_tready drops only when all seven
//   stages hold data and m_tready is low. Nothing is lost or repeated.
//   Reset: rst (synchronous, active high) empties the pipeline; m_tvalid is
//   low in the cycle after reset.
`default_nettype none
`include "assert_macros.svh"
module hsv_to_rgb_pwm_duty (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output      logic                     s_tready,
  // hue[8:0], saturation[15:9], brightness[22:16], zero fill [23]
  input  wire logic [hsvd_pkg::InW-1:0] s_tdata,
  output      logic                     m_tvalid,
  input  wire logic                     m_tready,
  // red_level[7:0], green_level[15:8], blue_level[23:16], red_duty[33:24],
  // green_duty[43:34], blue_duty[53:44], zero fill [55:54]
  output      logic [hsvd_pkg::OutW-1:0] m_tdata
);

  logic [7:1] vld;
  logic [7:1] en;

  // stage 1: clamp, sector, remainder
  logic [8:0]        hue_c;
  logic [6:0]        sat_c, bri_c;
  hsvd_pkg::sector_t sec_c;
  logic [8:0]        base_c;
  logic [8:0]        rem_w;
  hsvd_pkg::sector_t s1_sec;
  logic [5:0]        s1_rem;
  logic [6:0]        s1_sat, s1_bri;

  // stage 2: products
  hsvd_pkg::sector_t s2_sec;
  logic              s2_grey;
  logic [6:0]        s2_bri;
  logic [12:0]       s2_mq, s2_mt;
  logic [13:0]       s2_mp;

  // stage 3: divide by 60
  logic [27:0]       prod_q3, prod_t3;
  hsvd_pkg::sector_t s3_sec;
  logic              s3_grey;
  logic [6:0]        s3_bri, s3_qv, s3_tv;
  logic [13:0]       s3_mp;

  // stage 4: brightness products
  hsvd_pkg::sector_t s4_sec;
  logic              s4_grey;
  logic [6:0]        s4_bri;
  logic [13:0]       s4_mp, s4_mq, s4_mt;

  // stage 5: divide by 100
  logic [27:0]       prod_p5, prod_q5, prod_t5;
  hsvd_pkg::sector_t s5_sec;
  logic              s5_grey;
  logic [6:0]        s5_bri, s5_p, s5_q, s5_t;

  // stage 6: level scaling and select
  logic [24:0]       lv_v, lv_p, lv_q, lv_t;
  logic [7:0]        l_v, l_p, l_q, l_t;
  logic [7:0]        r_sel, g_sel, b_sel;
  logic [7:0]        s6_r, s6_g, s6_b;

  // stage 7: duty scaling
  logic [25:0]       d_r, d_g, d_b;
  logic [7:0]        s7_r, s7_g, s7_b;
  logic [9:0]        s7_dr, s7_dg, s7_db;

  always_comb begin
    en[7] = !vld[7] || m_tready;
    for (int i = 6; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int i = 2; i <= 7; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_comb begin
    hue_c = (s_tdata[8:0] >= hsvd_pkg::HueLimit) ? hsvd_pkg::HueMax : s_tdata[8:0];
    sat_c = (s_tdata[15:9] > hsvd_pkg::PctMax) ? hsvd_pkg::PctMax : s_tdata[15:9];
    bri_c = (s_tdata[22:16] > hsvd_pkg::PctMax) ? hsvd_pkg::PctMax : s_tdata[22:16];
    if (hue_c >= 9'd300) begin
      sec_c  = hsvd_pkg::SECT_MAGENTA;
      base_c = 9'd300;
    end else if (hue_c >= 9'd240) begin
      sec_c  = hsvd_pkg::SECT_BLUE;
      base_c = 9'd240;
    end else if (hue_c >= 9'd180) begin
      sec_c  = hsvd_pkg::SECT_CYAN;
      base_c = 9'd180;
    end else if (hue_c >= 9'd120) begin
      sec_c  = hsvd_pkg::SECT_GREEN;
      base_c = 9'd120;
    end else if (hue_c >= 9'd60) begin
      sec_c  = hsvd_pkg::SECT_YELLOW;
      base_c = 9'd60;
    end else begin
      sec_c  = hsvd_pkg::SECT_RED;
      base_c = 9'd0;
    end
    rem_w = hue_c - base_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sec <= sec_c;
      s1_rem <= rem_w[5:0];
      s1_sat <= sat_c;
      s1_bri <= bri_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sec  <= s1_sec;
      s2_grey <= (s1_sat == 7'd0);
      s2_bri  <= s1_bri;
      s2_mq   <= 13'(s1_sat) * 13'(s1_rem);
      s2_mt   <= 13'(s1_sat) * 13'(hsvd_pkg::SectorSpan - s1_rem);
      s2_mp   <= 14'(s1_bri) * 14'(hsvd_pkg::PctMax - s1_sat);
    end
  end

  assign prod_q3 = 28'(s2_mq) * 28'(hsvd_pkg::Recip60);
  assign prod_t3 = 28'(s2_mt) * 28'(hsvd_pkg::Recip60);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sec  <= s2_sec;
      s3_grey <= s2_grey;
      s3_bri  <= s2_bri;
      s3_mp   <= s2_mp;
      s3_qv   <= hsvd_pkg::PctMax - prod_q3[26:20];
      s3_tv   <= hsvd_pkg::PctMax - prod_t3[26:20];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_sec  <= s3_sec;
      s4_grey <= s3_grey;
      s4_bri  <= s3_bri;
      s4_mp   <= s3_mp;
      s4_mq   <= 14'(s3_bri) * 14'(s3_qv);
      s4_mt   <= 14'(s3_bri) * 14'(s3_tv);
    end
  end

  assign prod_p5 = 28'(s4_mp) * 28'(hsvd_pkg::Recip100);
  assign prod_q5 = 28'(s4_mq) * 28'(hsvd_pkg::Recip100);
  assign prod_t5 = 28'(s4_mt) * 28'(hsvd_pkg::Recip100);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_sec  <= s4_sec;
      s5_grey <= s4_grey;
      s5_bri  <= s4_bri;
      s5_p    <= prod_p5[26:20];
      s5_q    <= prod_q5[26:20];
      s5_t    <= prod_t5[26:20];
    end
  end

  assign lv_v = 25'(s5_bri) * 25'(hsvd_pkg::LevelScale);
  assign lv_p = 25'(s5_p) * 25'(hsvd_pkg::LevelScale);
  assign lv_q = 25'(s5_q) * 25'(hsvd_pkg::LevelScale);
  assign lv_t = 25'(s5_t) * 25'(hsvd_pkg::LevelScale);
  assign l_v  = lv_v[23:16];
  assign l_p  = lv_p[23:16];
  assign l_q  = lv_q[23:16];
  assign l_t  = lv_t[23:16];

  always_comb begin
    case (s5_sec)
      hsvd_pkg::SECT_RED: begin
        r_sel = l_v; g_sel = l_t; b_sel = l_p;
      end
      hsvd_pkg::SECT_YELLOW: begin
        r_sel = l_q; g_sel = l_v; b_sel = l_p;
      end
      hsvd_pkg::SECT_GREEN: begin
        r_sel = l_p; g_sel = l_v; b_sel = l_t;
      end
      hsvd_pkg::SECT_CYAN: begin
        r_sel = l_p; g_sel = l_q; b_sel = l_v;
      end
      hsvd_pkg::SECT_BLUE: begin
        r_sel = l_t; g_sel = l_p; b_sel = l_v;
      end
      default: begin
        r_sel = l_v; g_sel = l_p; b_sel = l_q;
      end
    endcase
    if (s5_grey) begin
      r_sel = l_v; g_sel = l_v; b_sel = l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_r <= r_sel;
      s6_g <= g_sel;
      s6_b <= b_sel;
    end
  end

  assign d_r = 26'(s6_r) * 26'(hsvd_pkg::DutyScale);
  assign d_g = 26'(s6_g) * 26'(hsvd_pkg::DutyScale);
  assign d_b = 26'(s6_b) * 26'(hsvd_pkg::DutyScale);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_r  <= s6_r;
      s7_g  <= s6_g;
      s7_b  <= s6_b;
      s7_dr <= d_r[25:16];
      s7_dg <= d_g[25:16];
      s7_db <= d_b[25:16];
    end
  end

  assign m_tvalid = vld[7];
  assign m_tdata  = {2'b00, s7_db, s7_dg, s7_dr, s7_b, s7_g, s7_r};

  `ASSERT_CLK(a_ready_when_out_empty, clk, rst, !m_tvalid |-> s_tready)
  `ASSERT_CLK(a_duty_range, clk, rst, m_tvalid |-> (m_tdata[33:24] <= 10'd1000))
  `ASSERT_CLK(a_full_level_full_duty, clk, rst,
    (m_tvalid && m_tdata[7:0] == 8'hFF) |-> (m_tdata[33:24] == 10'd1000))
  `ASSERT_CLK_NORST(a_empty_after_reset, clk, rst |=> !m_tvalid)

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for hsv_to_rgb_pwm_duty: streams colors with random
// idling on both sides and checks every result against a local predictor.
// Depends on hsvd_pkg and the RTL of hsv_to_rgb_pwm_duty.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LevelTop  = 255;
  localparam int unsigned DutyTop   = 1000;
  localparam int          RandCount = 1550;
  localparam int          DirCount  = 24;
  localparam int          CycleCap  = 600000;

  localparam logic [hsvd_pkg::HueW-1:0] DirHue [DirCount] = '{
    0, 30, 59, 60, 90, 119, 120, 179, 180, 239, 240, 299,
    300, 359, 360, 511, 0, 200, 45, 330, 100, 255, 1, 0};
  localparam logic [hsvd_pkg::PctW-1:0] DirSat [DirCount] = '{
    100, 50, 100, 100, 1, 100, 100, 127, 0, 64, 100, 99,
    101, 100, 100, 127, 0, 50, 1, 100, 0, 85, 127, 1};
  localparam logic [hsvd_pkg::PctW-1:0] DirBri [DirCount] = '{
    100, 100, 127, 1, 100, 50, 0, 100, 127, 100, 101, 64,
    100, 100, 100, 127, 0, 50, 99, 1, 100, 42, 85, 100};

  typedef struct packed {
    logic [hsvd_pkg::DutyW-1:0]  blue_duty;
    logic [hsvd_pkg::DutyW-1:0]  green_duty;
    logic [hsvd_pkg::DutyW-1:0]  red_duty;
    logic [hsvd_pkg::LevelW-1:0] blue_level;
    logic [hsvd_pkg::LevelW-1:0] green_level;
    logic [hsvd_pkg::LevelW-1:0] red_level;
  } color_result_t;

  class color_scoreboard;
    color_result_t expected_colors[$];
    int            mismatches;
    int            checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    function color_result_t predict_color(logic [hsvd_pkg::HueW-1:0] hue_in,
                                          logic [hsvd_pkg::PctW-1:0] sat_in,
                                          logic [hsvd_pkg::PctW-1:0] bri_in);
      int unsigned       h, s, v, frac, vl, pl, ql, tl, r, g, b;
      hsvd_pkg::sector_t sect;
      color_result_t     res;
      h = (hue_in >= hsvd_pkg::HueLimit) ? hsvd_pkg::HueMax : hue_in;
      s = (sat_in > hsvd_pkg::PctMax) ? hsvd_pkg::PctMax : sat_in;
      v = (bri_in > hsvd_pkg::PctMax) ? hsvd_pkg::PctMax : bri_in;
      vl = v * LevelTop / hsvd_pkg::PctMax;
      if (s == 0) begin
        r = vl;
        g = vl;
        b = vl;
      end else begin
        sect = hsvd_pkg::sector_t'(h / hsvd_pkg::SectorSpan);
        frac = (h - (h / hsvd_pkg::SectorSpan) * hsvd_pkg::SectorSpan) * 6;
        pl = (v * (hsvd_pkg::PctMax - s) / hsvd_pkg::PctMax) * LevelTop
             / hsvd_pkg::PctMax;
        ql = (v * (hsvd_pkg::PctMax - s * frac / hsvd_pkg::HueLimit)
             / hsvd_pkg::PctMax) * LevelTop / hsvd_pkg::PctMax;
        tl = (v * (hsvd_pkg::PctMax - s * (hsvd_pkg::HueLimit - frac)
             / hsvd_pkg::HueLimit) / hsvd_pkg::PctMax) * LevelTop / hsvd_pkg::PctMax;
        case (sect)
          hsvd_pkg::SECT_RED: begin
            r = vl; g = tl; b = pl;
          end
          hsvd_pkg::SECT_YELLOW: begin
            r = ql; g = vl; b = pl;
          end
          hsvd_pkg::SECT_GREEN: begin
            r = pl; g = vl; b = tl;
          end
          hsvd_pkg::SECT_CYAN: begin
            r = pl; g = ql; b = vl;
          end
          hsvd_pkg::SECT_BLUE: begin
            r = tl; g = pl; b = vl;
          end
          default: begin
            r = vl; g = pl; b = ql;
          end
        endcase
      end
      res.red_level   = r[hsvd_pkg::LevelW-1:0];
      res.green_level = g[hsvd_pkg::LevelW-1:0];
      res.blue_level  = b[hsvd_pkg::LevelW-1:0];
      res.red_duty    = 10'(res.red_level * DutyTop / LevelTop);
      res.green_duty  = 10'(res.green_level * DutyTop / LevelTop);
      res.blue_duty   = 10'(res.blue_level * DutyTop / LevelTop);
      return res;
    endfunction

    function void note_color(logic [hsvd_pkg::InW-1:0] word);
      expected_colors.push_back(predict_color(word[8:0], word[15:9], word[22:16]));
    endfunction

    function void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
      end
    endfunction

    function void check_color(logic [hsvd_pkg::OutW-1:0] word);
      color_result_t want, got;
      got = color_result_t'(word[$bits(color_result_t)-1:0]);
      if (expected_colors.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual %h", $time, word);
        return;
      end
      want = expected_colors.pop_front();
      checked++;
      compare_field("red_level", want.red_level, got.red_level);
      compare_field("green_level", want.green_level, got.green_level);
      compare_field("blue_level", want.blue_level, got.blue_level);
      compare_field("red_duty", want.red_duty, got.red_duty);
      compare_field("green_duty", want.green_duty, got.green_duty);
      compare_field("blue_duty", want.blue_duty, got.blue_duty);
    endfunction
  endclass

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [hsvd_pkg::InW-1:0]  s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [hsvd_pkg::OutW-1:0] m_tdata;

  logic            idle_on  = 1'b1;
  int              cycles   = 0;
  int              sent     = 0;
  color_scoreboard sb       = new();

  hsv_to_rgb_pwm_duty dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               sb.expected_colors.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_color(s_tdata);
      if (m_tvalid && m_tready)
        sb.check_color(m_tdata);
    end
  end

  initial begin : ready_side
    int unsigned run;
    forever begin
      run = $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_color(input logic [hsvd_pkg::HueW-1:0] hue,
                            input logic [hsvd_pkg::PctW-1:0] sat,
                            input logic [hsvd_pkg::PctW-1:0] bri);
    s_tdata  <= {1'b0, bri, sat, hue};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [hsvd_pkg::HueW-1:0] hue;
    logic [hsvd_pkg::PctW-1:0] sat, bri;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirCount; i++)
      send_color(DirHue[i], DirSat[i], DirBri[i]);

    for (int n = 0; n < RandCount; n++) begin
      if (n % 100 == 0)
        idle_on <= (n < RandCount - 150) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       hue = 9'($urandom_range(360, 511));
        1:       hue = 9'($urandom_range(0, 5) * 60 + $urandom_range(0, 1) * 59);
        default: hue = 9'($urandom_range(0, 359));
      endcase
      case ($urandom_range(0, 19))
        0:       sat = 7'($urandom_range(101, 127));
        1:       sat = '0;
        2:       sat = hsvd_pkg::PctMax;
        default: sat = 7'($urandom_range(1, 100));
      endcase
      case ($urandom_range(0, 19))
        0:       bri = 7'($urandom_range(101, 127));
        1:       bri = '0;
        2:       bri = hsvd_pkg::PctMax;
        default: bri = 7'($urandom_range(0, 100));
      endcase
      send_color(hue, sat, bri);
    end
    s_tvalid <= 1'b0;

    while (sb.expected_colors.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d colors (%0d directed) with idling on both sides;", sent, DirCount);
    $display("checked %0d results, %0d field mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.checked == sent)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+src
src/hsvd_pkg.sv
src/hsv_to_rgb_pwm_duty.sv
bench/tb.sv
